[sv/i2dec_pkg.sv]
// Package: shared constants and types for the binary to decimal ASCII converter.
`timescale 1ns / 1ps

package i2dec_pkg;

    localparam int VAL_W          = 32;
    localparam int NUM_DIGITS     = 10;
    localparam int BCD_W          = 4 * NUM_DIGITS;
    localparam int NUM_STAGES     = 4;
    localparam int BITS_PER_STAGE = VAL_W / NUM_STAGES;
    localparam int IDX_W          = $clog2(NUM_DIGITS);

    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_MINUS = 8'h2D;

    typedef logic [3:0] t_digit;

    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
        logic [VAL_W-1:0] bin;
    } t_stage;

endpackage

[sv/i2dec_if.sv]
// Interfaces: input number channel and output character channel.
`timescale 1ns / 1ps

interface i2dec_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface i2dec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

[sv/i2dec_dabble.sv]
// Double-dabble pipeline stage: shift-add-3 over one slice of the binary bits.
`timescale 1ns / 1ps

module i2dec_dabble (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  i2dec_pkg::t_stage  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output i2dec_pkg::t_stage  o_data
);

    function automatic logic [i2dec_pkg::BCD_W+i2dec_pkg::VAL_W-1:0] f_dabble(
        input logic [i2dec_pkg::BCD_W+i2dec_pkg::VAL_W-1:0] x
    );
        logic [i2dec_pkg::BCD_W+i2dec_pkg::VAL_W-1:0] t;
        t = x;
        for (int it = 0; it < i2dec_pkg::BITS_PER_STAGE; it++) begin
            for (int d = 0; d < i2dec_pkg::NUM_DIGITS; d++) begin
                if (t[i2dec_pkg::VAL_W + 4*d +: 4] >= 4'd5) begin
                    t[i2dec_pkg::VAL_W + 4*d +: 4] = t[i2dec_pkg::VAL_W + 4*d +: 4] + 4'd3;
                end
            end
            t = {t[i2dec_pkg::BCD_W+i2dec_pkg::VAL_W-2:0], 1'b0};
        end
        return t;
    endfunction

    logic              r_valid;
    i2dec_pkg::t_stage r_data;
    i2dec_pkg::t_stage n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data     = i_data;
        {n_data.bcd, n_data.bin} = f_dabble({i_data.bcd, i_data.bin});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

[sv/int32_to_decimal_ascii.sv]
// Top level: 32-bit binary to decimal ASCII character stream converter.
//
//  channel  dir  payload                    transaction
//  i_in     in   func, value[31:0]          one number to convert
//  o_out    out  char_code[7:0], last       one character, last ends the run
//
//  Pipeline: sign/magnitude stage, four double-dabble stages of eight bits each,
//  then a character serializer, each stage with its own register. Serializer
//  sends one character per cycle while o_out is ready; a number is 1 to 11
//  characters (sign plus digits); runs follow with no gap if the next one waits.
//  Reset (synchronous, active low) clears all valid bits; payload is not reset.
//  A stall on o_out backs up through every stage; nothing is dropped or repeated.
`timescale 1ns / 1ps

module int32_to_decimal_ascii (
    input  logic         i_clk,
    input  logic         i_rst_n,
    i2dec_in_if.sink     i_in,
    i2dec_out_if.source  o_out
);

    // sign and magnitude stage
    logic              r_s0_v;
    i2dec_pkg::t_stage r_s0;
    i2dec_pkg::t_stage n_s0;
    logic              w_s0_rdy;

    logic              w_v   [0:i2dec_pkg::NUM_STAGES];
    logic              w_rdy [0:i2dec_pkg::NUM_STAGES];
    i2dec_pkg::t_stage w_st  [0:i2dec_pkg::NUM_STAGES];

    assign w_s0_rdy   = !r_s0_v || w_rdy[0];
    assign i_in.ready = w_s0_rdy;

    always_comb begin
        n_s0.neg = i_in.func & i_in.value[i2dec_pkg::VAL_W-1];
        n_s0.bcd = '0;
        n_s0.bin = n_s0.neg ? (i2dec_pkg::VAL_W)'(0 - i_in.value) : i_in.value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (w_s0_rdy) begin
            r_s0_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s0_rdy && i_in.valid) begin
            r_s0 <= n_s0;
        end
    end

    assign w_v[0]  = r_s0_v;
    assign w_st[0] = r_s0;

    // binary to BCD
    for (genvar k = 0; k < i2dec_pkg::NUM_STAGES; k++) begin : g_dabble
        i2dec_dabble u_dabble (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[k]),
            .o_ready (w_rdy[k]),
            .i_data  (w_st[k]),
            .o_valid (w_v[k+1]),
            .i_ready (w_rdy[k+1]),
            .o_data  (w_st[k+1])
        );
    end

    // character serializer
    logic                        r_ser_v;
    logic                        r_ser_neg;
    i2dec_pkg::t_digit           r_ser_dig [0:i2dec_pkg::NUM_DIGITS-1];
    logic [i2dec_pkg::IDX_W-1:0] r_ser_idx;
    logic [i2dec_pkg::IDX_W-1:0] w_top;
    logic                        w_ser_last;
    logic                        w_ser_load;

    always_comb begin
        w_top = '0;
        for (int d = 0; d < i2dec_pkg::NUM_DIGITS; d++) begin
            if (w_st[i2dec_pkg::NUM_STAGES].bcd[4*d +: 4] != 4'd0) begin
                w_top = (i2dec_pkg::IDX_W)'(d);
            end
        end
    end

    assign w_ser_last = !r_ser_neg && (r_ser_idx == '0);
    assign w_ser_load = !r_ser_v || (o_out.ready && w_ser_last);
    assign w_rdy[i2dec_pkg::NUM_STAGES] = w_ser_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_v <= 1'b0;
        end else if (w_ser_load) begin
            r_ser_v <= w_v[i2dec_pkg::NUM_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ser_load && w_v[i2dec_pkg::NUM_STAGES]) begin
            r_ser_neg <= w_st[i2dec_pkg::NUM_STAGES].neg;
            r_ser_idx <= w_top;
            for (int d = 0; d < i2dec_pkg::NUM_DIGITS; d++) begin
                r_ser_dig[d] <= w_st[i2dec_pkg::NUM_STAGES].bcd[4*d +: 4];
            end
        end else if (r_ser_v && o_out.ready) begin
            if (r_ser_neg) begin
                r_ser_neg <= 1'b0;
            end else begin
                r_ser_idx <= r_ser_idx - 1'b1;
            end
        end
    end

    assign o_out.valid     = r_ser_v;
    assign o_out.last      = w_ser_last;
    assign o_out.char_code = r_ser_neg ? i2dec_pkg::CHR_MINUS
                                       : i2dec_pkg::CHR_ZERO + {4'd0, r_ser_dig[r_ser_idx]};

    // checks
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.char_code == i2dec_pkg::CHR_MINUS) |-> !o_out.last)
        else $error("minus sign flagged as last character");

    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last) |=> o_out.valid)
        else $error("character run broken before last");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.char_code != i2dec_pkg::CHR_MINUS) |->
        (o_out.char_code >= i2dec_pkg::CHR_ZERO && o_out.char_code <= i2dec_pkg::CHR_NINE))
        else $error("character is not a decimal digit");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

endmodule
